// ----- src/mpe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_pkg: shared definitions for the Mandelbrot pixel engine
// Fixed-point constants, register map, configuration struct and the
// elaboration-time color ramp function.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Image and iteration defaults.
  localparam int IMG_WIDTH_DEF  = 1024;
  localparam int IMG_HEIGHT_DEF = 1024;
  localparam int MAX_ITER_DEF   = 500;

  // Field widths.
  localparam int POS_W   = 10;
  localparam int ITER_W  = 9;
  localparam int RED_W   = 8;
  localparam int GB_W    = 6;
  localparam int Q_W     = 32;
  localparam int STEP_W  = 31;
  localparam int PROD_W  = 2 * Q_W;

  // Signed Q4.28 arithmetic.
  localparam int FRAC_BITS = 28;
  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  // Color ramp.
  localparam int RED_FULL = 255;
  localparam int GB_FULL  = 55;

  // Configuration register map (word index = paddr[3:2]).
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_CENTER_RE  = 2'd0;
  localparam logic [1:0] REG_CENTER_IM  = 2'd1;
  localparam logic [1:0] REG_PIXEL_STEP = 2'd2;

  localparam logic signed [Q_W-1:0] CENTER_RE_RST  = -32'sd134217728;
  localparam logic signed [Q_W-1:0] CENTER_IM_RST  = 32'sd0;
  localparam logic [STEP_W-1:0]     PIXEL_STEP_RST = 31'd786432;

  typedef struct packed {
    logic signed [Q_W-1:0] center_re;
    logic signed [Q_W-1:0] center_im;
    logic [STEP_W-1:0]     pixel_step;
  } cfg_t;

  // Control from the iteration sequencer to the color stage.
  typedef struct packed {
    logic valid;
    logic escaped;
  } res_ctl_t;

  // Saturate a wide signed sum to signed Q4.28.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W:0] v);
    logic signed [Q_W-1:0] r;
    if (!v[PROD_W] && (|v[PROD_W-1:Q_W-1])) begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v[PROD_W] && !(&v[PROD_W-1:Q_W-1])) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // floor(full * (n / max_iter)^0.58), evaluated at elaboration only.
  function automatic int gamma_level(input int n, input int max_iter, input int full);
    real g;
    int  r;
    if (n <= 0) begin
      r = 0;
    end else begin
      g = $pow(real'(n), 0.58) * $pow(real'(max_iter), -0.58);
      r = int'($floor(real'(full) * g));
      if (r > full) begin
        r = full;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/mpe_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_ifs: valid/ready channel interfaces of the Mandelbrot pixel engine
// Pixel coordinate channel and pixel result channel.
// ----------------------------------------------------------------------------
interface mpe_pixel_if import mpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] x_pos;
  logic [POS_W-1:0] y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

interface mpe_result_if import mpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iter_count;
  logic [RED_W-1:0]  red;
  logic [GB_W-1:0]   green;
  logic [GB_W-1:0]   blue;

  modport source (output valid, output iter_count, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input iter_count, input red, input green,
                  input blue, output ready);
endinterface
`default_nettype wire

// ----- src/mandelbrot_pixel_engine.sv -----
`default_nettype none
// Each iteration of z runs through S_SQ_RE, S_SQ_IM, S_CHECK and S_UPDATE on the
// shared multiplier. The engine works on one pixel at a time: the input is ready
// only while the sequencer is idle, and an unread result stalls it only once the
// next pixel has finished too.
// Reset: synchronous, active low; control and configuration registers are reset.
// ----------------------------------------------------------------------------
// mandelbrot_pixel_engine: Mandelbrot escape-time pixel engine
// Maps a pixel to the complex plane, counts iterations to escape and colors it.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_engine import mpe_pkg::*; #(
  parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
  parameter int MAX_ITER   = MAX_ITER_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mpe_pixel_if.sink              in_pix,
  mpe_result_if.source           out_pix,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);

  cfg_t             cfg;
  res_ctl_t         res;
  logic [CNT_W-1:0] res_count;
  logic             res_ready;

  mpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpe_core #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .MAX_ITER   (MAX_ITER),
    .CNT_W      (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pix       (in_pix),
    .res       (res),
    .res_count (res_count),
    .res_ready (res_ready)
  );

  mpe_color #(
    .MAX_ITER (MAX_ITER),
    .CNT_W    (CNT_W)
  ) u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_count (res_count),
    .res_ready (res_ready),
    .out       (out_pix)
  );

endmodule
`default_nettype wire

// ----- src/mpe_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_cfg: APB configuration registers
// View center and pixel step, written and read over an APB-style port.
// ----------------------------------------------------------------------------
module mpe_cfg import mpe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_re  <= CENTER_RE_RST;
      cfg_r.center_im  <= CENTER_IM_RST;
      cfg_r.pixel_step <= PIXEL_STEP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_RE:  cfg_r.center_re  <= pwdata;
        REG_CENTER_IM:  cfg_r.center_im  <= pwdata;
        REG_PIXEL_STEP: cfg_r.pixel_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_RE:  prdata = cfg_r.center_re;
      REG_CENTER_IM:  prdata = cfg_r.center_im;
      REG_PIXEL_STEP: prdata = {1'b0, cfg_r.pixel_step};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/mpe_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_mul: shared signed multiplier
// One 32x32 signed product per cycle with a registered result.
// ----------------------------------------------------------------------------
module mpe_mul import mpe_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [Q_W-1:0]    op_a,
  input  wire logic signed [Q_W-1:0]    op_b,
  output logic signed      [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ----- src/mpe_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_core: coordinate mapping and escape-time sequencer
// Maps a pixel to c and iterates z = z*z + c on the shared multiplier.
// ----------------------------------------------------------------------------
module mpe_core import mpe_pkg::*; #(
  parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
  parameter int MAX_ITER   = MAX_ITER_DEF,
  parameter int CNT_W      = $clog2(MAX_ITER + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  mpe_pixel_if.sink             pix,
  output res_ctl_t              res,
  output logic [CNT_W-1:0]      res_count,
  input  wire logic             res_ready
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MAP_X   = 4'd1;
  localparam logic [3:0] S_MAP_Y   = 4'd2;
  localparam logic [3:0] S_MAP_FIN = 4'd3;
  localparam logic [3:0] S_SQ_RE   = 4'd4;
  localparam logic [3:0] S_SQ_IM   = 4'd5;
  localparam logic [3:0] S_CHECK   = 4'd6;
  localparam logic [3:0] S_UPDATE  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  localparam logic signed [Q_W-1:0] SIZE_X = Q_W'(IMG_WIDTH);
  localparam logic signed [Q_W-1:0] SIZE_Y = Q_W'(IMG_HEIGHT);
  localparam logic [CNT_W-1:0]      LAST_K = CNT_W'(MAX_ITER);

  logic [3:0]               state_r, state_nxt;
  logic [POS_W-1:0]         x_r, y_r;
  logic signed [Q_W-1:0]    cre_r, cim_r;
  logic signed [Q_W-1:0]    re_r, im_r;
  logic signed [PROD_W-1:0] rr_r, diff_r;
  logic [CNT_W-1:0]         k_r, count_r;
  logic                     escaped_r;

  logic signed [Q_W-1:0]    op_a, op_b, off_x, off_y, step_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   map_re, map_im, upd_re, upd_im;
  logic [PROD_W-1:0]        mag;
  logic                     escape, accept;

  mpe_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign pix.ready = (state_r == S_IDLE);
  assign accept    = pix.valid && pix.ready;

  // Offsets are 2*pos - size, in half pixel steps.
  assign off_x  = $signed({{(Q_W-POS_W-1){1'b0}}, x_r, 1'b0}) - SIZE_X;
  assign off_y  = $signed({{(Q_W-POS_W-1){1'b0}}, y_r, 1'b0}) - SIZE_Y;
  assign step_s = $signed({1'b0, cfg.pixel_step});

  always_comb begin
    unique case (state_r)
      S_MAP_X: begin
        op_a = off_x;
        op_b = step_s;
      end
      S_MAP_Y: begin
        op_a = off_y;
        op_b = step_s;
      end
      S_SQ_RE: begin
        op_a = re_r;
        op_b = re_r;
      end
      S_SQ_IM: begin
        op_a = im_r;
        op_b = im_r;
      end
      default: begin
        op_a = re_r;
        op_b = im_r;
      end
    endcase
  end

  assign map_re = (PROD_W+1)'(prod >>> 1) + (PROD_W+1)'(cfg.center_re);
  assign map_im = (PROD_W+1)'(prod >>> 1) + (PROD_W+1)'(cfg.center_im);
  assign upd_re = (PROD_W+1)'(diff_r >>> FRAC_BITS) + (PROD_W+1)'(cre_r);
  assign upd_im = (PROD_W+1)'(prod >>> (FRAC_BITS - 1)) + (PROD_W+1)'(cim_r);

  // Both squares are non-negative, so the magnitude fits unsigned 64 bits.
  assign mag    = unsigned'(rr_r) + unsigned'(prod);
  assign escape = mag > ESCAPE_LIMIT;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (accept) state_nxt = S_MAP_X;
      S_MAP_X:   state_nxt = S_MAP_Y;
      S_MAP_Y:   state_nxt = S_MAP_FIN;
      S_MAP_FIN: state_nxt = S_SQ_RE;
      S_SQ_RE:   state_nxt = S_SQ_IM;
      S_SQ_IM:   state_nxt = S_CHECK;
      S_CHECK: begin
        if (escape || (k_r == LAST_K)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE:  state_nxt = S_SQ_RE;
      S_DONE:    if (res_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The check of pass k tests the z produced by update k-1; z = 0 never escapes.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= pix.x_pos;
      y_r <= pix.y_pos;
    end
    unique case (state_r)
      S_MAP_Y: cre_r <= sat_q(map_re);
      S_MAP_FIN: begin
        cim_r <= sat_q(map_im);
        re_r  <= '0;
        im_r  <= '0;
        k_r   <= '0;
      end
      S_SQ_IM: rr_r <= prod;
      S_CHECK: begin
        diff_r <= rr_r - prod;
        if (escape) begin
          count_r   <= k_r - CNT_W'(1);
          escaped_r <= 1'b1;
        end else begin
          count_r   <= k_r;
          escaped_r <= 1'b0;
        end
      end
      S_UPDATE: begin
        re_r <= sat_q(upd_re);
        im_r <= sat_q(upd_im);
        k_r  <= k_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign res.valid   = (state_r == S_DONE);
  assign res.escaped = escaped_r;
  assign res_count   = count_r;

endmodule
`default_nettype wire

// ----- src/mpe_color.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_color: color ramp lookup and result register
// Looks up the gamma ramp for an escape count and holds the pixel result.
// ----------------------------------------------------------------------------
module mpe_color import mpe_pkg::*; #(
  parameter int MAX_ITER = MAX_ITER_DEF,
  parameter int CNT_W    = $clog2(MAX_ITER + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire res_ctl_t         res,
  input  wire logic [CNT_W-1:0] res_count,
  output logic                  res_ready,
  mpe_result_if.source          out
);

  localparam int IDX_W = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

  logic [RED_W-1:0]  red_tab [MAX_ITER];
  logic [GB_W-1:0]   gb_tab  [MAX_ITER];
  logic [IDX_W-1:0]  idx;
  logic              accept;

  logic              out_valid_r;
  logic [ITER_W-1:0] iter_r;
  logic [RED_W-1:0]  red_r;
  logic [GB_W-1:0]   gb_r;

  for (genvar n = 0; n < MAX_ITER; n++) begin : g_tab
    localparam int RedVal = gamma_level(n, MAX_ITER, RED_FULL);
    localparam int GbVal  = gamma_level(n, MAX_ITER, GB_FULL);
    assign red_tab[n] = RED_W'(RedVal);
    assign gb_tab[n]  = GB_W'(GbVal);
  end

  assign idx       = res_count[IDX_W-1:0];
  assign res_ready = !out_valid_r || out.ready;
  assign accept    = res.valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Points inside the set are black.
  always_ff @(posedge clk) begin
    if (accept) begin
      iter_r <= ITER_W'(res_count);
      red_r  <= res.escaped ? red_tab[idx] : '0;
      gb_r   <= res.escaped ? gb_tab[idx] : '0;
    end
  end

  assign out.valid      = out_valid_r;
  assign out.iter_count = iter_r;
  assign out.red        = red_r;
  assign out.green      = gb_r;
  assign out.blue       = gb_r;

endmodule
`default_nettype wire
